>>> src/ecal_pkg.sv
// Shared widths, constants and record types for the epoch-to-calendar converter.
package ecal_pkg;

  // Configuration and result field widths.
  localparam int ZONE_W  = 5;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DOM_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int MSEC_W  = 10;

  // Whole days since the epoch and milliseconds within one day.
  localparam int DAYS_W  = 22;
  localparam int MSDAY_W = 27;

  // Width to which the zoned timestamp is widened before the day split.
  localparam int SPLIT_W = 49;

  // Register stages inside each of the date and time-of-day pipelines.
  localparam int CORE_STAGES = 6;

  localparam longint unsigned MS_PER_SEC  = 64'd1000;
  localparam longint unsigned MS_PER_MIN  = 64'd60000;
  localparam longint unsigned MS_PER_HOUR = 64'd3600000;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DOM_W-1:0]   day_of_month;
  } ecal_date_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [MSEC_W-1:0] millisecond;
  } ecal_tod_t;

endpackage

>>> src/ecal_if.sv
// Valid/ready channel interfaces for timestamps, results and configuration.
interface ecal_in_if #(
  parameter int STAMP_BITS = 44
) ();
  logic                  valid;
  logic                  ready;
  logic [STAMP_BITS-1:0] epoch_millis;

  modport source (output valid, output epoch_millis, input ready);
  modport sink (input valid, input epoch_millis, output ready);
  modport monitor (input valid, input ready, input epoch_millis);
endinterface

interface ecal_cfg_if
  import ecal_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ZONE_W-1:0] zone_offset_hours;

  modport source (output valid, output zone_offset_hours, input ready);
  modport sink (input valid, input zone_offset_hours, output ready);
  modport monitor (input valid, input ready, input zone_offset_hours);
endinterface

interface ecal_out_if
  import ecal_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DOM_W-1:0]   day_of_month;
  logic [HOUR_W-1:0]  hour;
  logic [MIN_W-1:0]   minute;
  logic [SEC_W-1:0]   second;
  logic [MSEC_W-1:0]  millisecond;

  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, output second, output millisecond,
                  input ready);
  modport sink (input valid, input year, input month, input day_of_month,
                input hour, input minute, input second, input millisecond,
                output ready);
  modport monitor (input valid, input ready, input year, input month,
                   input day_of_month, input hour, input minute, input second,
                   input millisecond);
endinterface

>>> src/epoch_ms_to_calendar_time.sv
// Top level: epoch milliseconds plus zone offset to calendar date and time of day.
//
//   channel  direction  word
//   -------  ---------  ------------------------------------------------------------
//   stamp    in         epoch_millis
//   cfg      in         zone_offset_hours (whole hours, always ready)
//   result   out        year, month, day_of_month, hour, minute, second, millisecond
//
// One word is taken on every cycle while the skid register is empty; a result
// passes through the ten-stage pipeline and then the output register.
// Reset (rst, synchronous) clears the stage valid bits, the output and skid
// flags and the zone offset register; payload registers are not reset.
// A stall at result freezes the pipeline only once a word leaves the last stage
// while the output register is held: that word lands in the skid register and
// stamp.ready drops until the skid word has moved on to the output register.
module epoch_ms_to_calendar_time
  import ecal_pkg::*;
#(
  parameter int STAMP_BITS = 44
) (
  input logic      clk,
  input logic      rst,
  ecal_in_if.sink  stamp,
  ecal_cfg_if.sink cfg,
  ecal_out_if.source result
);

  localparam int TOTAL_W = STAMP_BITS + 1;
  localparam int STAGES  = 4 + CORE_STAGES;

  // 86 400 000 ms per day is 2^10 times DAY_UNIT. The quotient by DAY_UNIT is
  // first estimated from the top 31 bits of the zoned stamp with a truncated
  // reciprocal. The estimate is never high and at most one low, so a single
  // compare and subtract on the remainder finishes the split.
  localparam longint unsigned DAY_UNIT  = 64'd84375;
  localparam longint unsigned DAY_RECIP = (64'd1 << 42) / 64'd84375;

  typedef struct packed {
    ecal_date_t date;
    ecal_tod_t  tod;
  } ecal_result_t;

  logic [ZONE_W-1:0]     zone;
  logic [STAGES-1:0]     vld;
  logic                  run;

  // Stage 0: captured timestamp. Stage 1: timestamp plus zone offset.
  logic [STAMP_BITS-1:0] s0_stamp;
  logic [TOTAL_W-1:0]    s1_total;
  // Stage 2: day estimate and the low bits needed for the remainder.
  logic [DAYS_W-1:0]     s2_q0;
  logic [27:0]           s2_low;
  // Stage 3: exact day count and millisecond of the day.
  logic [DAYS_W-1:0]     s3_days;
  logic [MSDAY_W-1:0]    s3_msday;

  logic [26:0]           zone_ms;
  logic [TOTAL_W-1:0]    total_next;
  logic [SPLIT_W-1:0]    split;
  logic [56:0]           day_prod;
  logic [17:0]           unit_prod;
  logic [17:0]           rem_raw;
  logic                  rem_wrap;
  logic [17:0]           rem;

  ecal_date_t            civil_date;
  ecal_tod_t             tod_now;
  ecal_result_t          fresh;
  ecal_result_t          out_q;
  ecal_result_t          skid_q;
  logic                  out_valid;
  logic                  skid_valid;
  logic                  incoming;
  logic                  load_out;

  // The pipeline only moves while the skid register is free, so ready is a
  // registered signal and never waits on result.ready.
  assign run         = !skid_valid;
  assign stamp.ready = run;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone <= '0;
    end else if (cfg.valid && cfg.ready) begin
      zone <= cfg.zone_offset_hours;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (run) begin
      vld <= {vld[STAGES-2:0], stamp.valid};
    end
  end

  always_comb begin
    zone_ms    = zone * 22'(MS_PER_HOUR);
    total_next = TOTAL_W'(s0_stamp) + TOTAL_W'(zone_ms);
    split      = SPLIT_W'(s1_total);
    day_prod   = split[SPLIT_W-1:18] * 26'(DAY_RECIP);
    // Only the low bits of the product matter: the true remainder is below
    // twice DAY_UNIT, which fits in 18 bits.
    unit_prod  = 18'(s2_q0 * 17'(DAY_UNIT));
    rem_raw    = s2_low[27:10] - unit_prod;
    rem_wrap   = (rem_raw >= 18'(DAY_UNIT));
    rem        = rem_wrap ? rem_raw - 18'(DAY_UNIT) : rem_raw;
  end

  always_ff @(posedge clk) begin
    if (run) begin
      s0_stamp <= stamp.epoch_millis[STAMP_BITS-1:0];
      s1_total <= total_next;
      s2_q0    <= day_prod[55:34];
      s2_low   <= split[27:0];
      s3_days  <= s2_q0 + DAYS_W'(rem_wrap);
      s3_msday <= {rem[16:0], s2_low[9:0]};
    end
  end

  // The date and the time of day run side by side with equal depth.
  ecal_civil u_civil (
    .clk  (clk),
    .en   (run),
    .days (s3_days),
    .date (civil_date)
  );

  ecal_tod u_tod (
    .clk   (clk),
    .en    (run),
    .msday (s3_msday),
    .tod   (tod_now)
  );

  assign fresh.date = civil_date;
  assign fresh.tod  = tod_now;

  // Output register with a one-word skid behind it. A word leaving the
  // pipeline goes straight to the output register when that is free or being
  // emptied; otherwise it waits in the skid register, which stops the pipe.
  assign incoming = run && vld[STAGES-1];
  assign load_out = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= incoming;
      end
    end else if (incoming) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (incoming) begin
      skid_q <= fresh;
    end
    if (load_out) begin
      out_q <= skid_valid ? skid_q : fresh;
    end
  end

  assign result.valid        = out_valid;
  assign result.year         = out_q.date.year;
  assign result.month        = out_q.date.month;
  assign result.day_of_month = out_q.date.day_of_month;
  assign result.hour         = out_q.tod.hour;
  assign result.minute       = out_q.tod.minute;
  assign result.second       = out_q.tod.second;
  assign result.millisecond  = out_q.tod.millisecond;

endmodule

>>> src/ecal_civil.sv
// Day count to proleptic Gregorian year, month and day, six register stages.
module ecal_civil
  import ecal_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [DAYS_W-1:0] days,
  output ecal_date_t        date
);

  // Days from 0000-03-01 to 1970-01-01, and days in a 400-year era.
  localparam longint unsigned EPOCH_SHIFT = 64'd719468;
  localparam longint unsigned ERA_DAYS    = 64'd146097;
  localparam longint unsigned ERA_LAST    = 64'd146096;
  localparam longint unsigned YEAR_DAYS   = 64'd365;

  // Reciprocals, each exact over the full input range of its stage.
  localparam longint unsigned ERA_RECIP  = ((64'd1 << 41) / 64'd146097) + 64'd1;
  localparam longint unsigned LEAP_RECIP = ((64'd1 << 29) / 64'd1460) + 64'd1;
  localparam longint unsigned CENT_RECIP = ((64'd1 << 34) / 64'd36524) + 64'd1;
  localparam longint unsigned YOE_RECIP  = ((64'd1 << 27) / 64'd365) + 64'd1;
  localparam longint unsigned Y100_RECIP = ((64'd1 << 16) / 64'd100) + 64'd1;
  localparam longint unsigned MP_RECIP   = ((64'd1 << 19) / 64'd153) + 64'd1;

  // First day of each month in a March-based year.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] start;
    case (mp)
      4'd0:    start = 9'd0;
      4'd1:    start = 9'd31;
      4'd2:    start = 9'd61;
      4'd3:    start = 9'd92;
      4'd4:    start = 9'd122;
      4'd5:    start = 9'd153;
      4'd6:    start = 9'd184;
      4'd7:    start = 9'd214;
      4'd8:    start = 9'd245;
      4'd9:    start = 9'd275;
      4'd10:   start = 9'd306;
      4'd11:   start = 9'd337;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

  logic [22:0] c1_shifted;
  logic [5:0]  c1_era;
  logic [5:0]  c2_era;
  logic [17:0] c2_doe;
  logic [5:0]  c3_era;
  logic [17:0] c3_doe;
  logic [17:0] c3_ynum;
  logic [5:0]  c4_era;
  logic [17:0] c4_doe;
  logic [8:0]  c4_yoe;
  logic [5:0]  c5_era;
  logic [8:0]  c5_yoe;
  logic [8:0]  c5_doy;
  logic [5:0]  c6_era;
  logic [8:0]  c6_yoe;
  logic [8:0]  c6_doy;
  logic [3:0]  c6_mp;

  logic [22:0] shifted;
  logic [46:0] era_prod;
  logic [22:0] era_days;
  logic [36:0] leap_prod;
  logic [36:0] cent_prod;
  logic        era_last;
  logic [17:0] ynum;
  logic [35:0] yoe_prod;
  logic [18:0] y100_prod;
  logic [17:0] year_start;
  logic [10:0] mp_num;
  logic [22:0] mp_prod;
  logic [4:0]  dom;
  logic [3:0]  mon;
  logic [13:0] yr;

  always_comb begin
    shifted   = 23'(days) + 23'(EPOCH_SHIFT);
    era_prod  = shifted * 24'(ERA_RECIP);
    era_days  = c1_era * 18'(ERA_DAYS);
    leap_prod = c2_doe * 19'(LEAP_RECIP);
    cent_prod = c2_doe * 19'(CENT_RECIP);
    era_last  = (c2_doe == 18'(ERA_LAST));
    ynum      = c2_doe - 18'(leap_prod[35:29]) + 18'(cent_prod[36:34]) - 18'(era_last);
    yoe_prod  = c3_ynum * 19'(YOE_RECIP);
    y100_prod = c4_yoe * 10'(Y100_RECIP);
    year_start = 18'(c4_yoe) * 18'(YEAR_DAYS) + 18'(c4_yoe[8:2]) - 18'(y100_prod[17:16]);
    mp_num    = 11'(c5_doy) * 11'd5 + 11'd2;
    mp_prod   = mp_num * 12'(MP_RECIP);
    dom       = 5'(c6_doy - month_start(c6_mp) + 9'd1);
    mon       = (c6_mp < 4'd10) ? c6_mp + 4'd3 : c6_mp - 4'd9;
    yr        = 14'(c6_yoe) + 14'(c6_era) * 14'd400 + 14'(mon <= 4'd2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_shifted <= shifted;
      c1_era     <= era_prod[46:41];
      c2_era     <= c1_era;
      c2_doe     <= 18'(c1_shifted - era_days);
      c3_era     <= c2_era;
      c3_doe     <= c2_doe;
      c3_ynum    <= ynum;
      c4_era     <= c3_era;
      c4_doe     <= c3_doe;
      c4_yoe     <= yoe_prod[35:27];
      c5_era     <= c4_era;
      c5_yoe     <= c4_yoe;
      c5_doy     <= 9'(c4_doe - year_start);
      c6_era     <= c5_era;
      c6_yoe     <= c5_yoe;
      c6_doy     <= c5_doy;
      c6_mp      <= mp_prod[22:19];
    end
  end

  assign date.year         = yr[YEAR_W-1:0];
  assign date.month        = mon;
  assign date.day_of_month = dom;

endmodule

>>> src/ecal_tod.sv
// Millisecond of the day to hour, minute, second and millisecond, six register stages.
module ecal_tod
  import ecal_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [MSDAY_W-1:0] msday,
  output ecal_tod_t          tod
);

  // Each divisor is split into a power of two, taken as a shift, and an odd
  // factor, taken by an exact reciprocal over the range of its stage.
  localparam longint unsigned HOUR_RECIP = ((64'd1 << 35) / 64'd28125) + 64'd1;
  localparam longint unsigned MIN_RECIP  = ((64'd1 << 28) / 64'd1875) + 64'd1;
  localparam longint unsigned SEC_RECIP  = ((64'd1 << 20) / 64'd125) + 64'd1;

  logic [26:0] t1_ms;
  logic [4:0]  t1_hour;
  logic [4:0]  t2_hour;
  logic [21:0] t2_rh;
  logic [4:0]  t3_hour;
  logic [21:0] t3_rh;
  logic [5:0]  t3_min;
  logic [4:0]  t4_hour;
  logic [5:0]  t4_min;
  logic [15:0] t4_rm;
  logic [4:0]  t5_hour;
  logic [5:0]  t5_min;
  logic [15:0] t5_rm;
  logic [5:0]  t5_sec;
  logic [4:0]  t6_hour;
  logic [5:0]  t6_min;
  logic [5:0]  t6_sec;
  logic [9:0]  t6_msec;

  logic [40:0] hour_prod;
  logic [26:0] hour_ms;
  logic [34:0] min_prod;
  logic [21:0] min_ms;
  logic [26:0] sec_prod;
  logic [15:0] sec_ms;

  always_comb begin
    hour_prod = msday[26:7] * 21'(HOUR_RECIP);
    hour_ms   = t1_hour * 22'(MS_PER_HOUR);
    min_prod  = t2_rh[21:5] * 18'(MIN_RECIP);
    min_ms    = t3_min * 16'(MS_PER_MIN);
    sec_prod  = t4_rm[15:3] * 14'(SEC_RECIP);
    sec_ms    = t5_sec * 10'(MS_PER_SEC);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_ms   <= msday;
      t1_hour <= hour_prod[39:35];
      t2_hour <= t1_hour;
      t2_rh   <= 22'(t1_ms - hour_ms);
      t3_hour <= t2_hour;
      t3_rh   <= t2_rh;
      t3_min  <= min_prod[33:28];
      t4_hour <= t3_hour;
      t4_min  <= t3_min;
      t4_rm   <= 16'(t3_rh - min_ms);
      t5_hour <= t4_hour;
      t5_min  <= t4_min;
      t5_rm   <= t4_rm;
      t5_sec  <= sec_prod[25:20];
      t6_hour <= t5_hour;
      t6_min  <= t5_min;
      t6_sec  <= t5_sec;
      t6_msec <= 10'(t5_rm - sec_ms);
    end
  end

  assign tod.hour        = t6_hour;
  assign tod.minute      = t6_min;
  assign tod.second      = t6_sec;
  assign tod.millisecond = t6_msec;

endmodule

>>> src/ecal_checker.sv
// Port-level checks for the epoch-to-calendar converter, bound to its top level.
module ecal_checker
  import ecal_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               stamp_valid,
  input logic               stamp_ready,
  input logic               result_valid,
  input logic               result_ready,
  input logic [YEAR_W-1:0]  year,
  input logic [MONTH_W-1:0] month,
  input logic [DOM_W-1:0]   day_of_month,
  input logic [HOUR_W-1:0]  hour,
  input logic [MIN_W-1:0]   minute,
  input logic [SEC_W-1:0]   second,
  input logic [MSEC_W-1:0]  millisecond
);

  // Month, hour, minute, second and millisecond are in range; day is at least 1.
  a_field_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (month >= 4'd1) && (month <= 4'd12) &&
                     (day_of_month >= 5'd1) && (hour <= 5'd23) &&
                     (minute <= 6'd59) && (second <= 6'd59) &&
                     (millisecond <= 10'd999))
    else $error("calendar field out of range");

  // A stalled result stays put.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid &&
      $stable(year) && $stable(month) && $stable(day_of_month) &&
      $stable(hour) && $stable(minute) && $stable(second) &&
      $stable(millisecond))
    else $error("stalled result changed");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // With the output empty the skid register is empty too, so input flows.
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> stamp_ready)
    else $error("input blocked while output is empty");

endmodule

bind epoch_ms_to_calendar_time ecal_checker u_ecal_checker (
  .clk          (clk),
  .rst          (rst),
  .stamp_valid  (stamp.valid),
  .stamp_ready  (stamp.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .year         (result.year),
  .month        (result.month),
  .day_of_month (result.day_of_month),
  .hour         (result.hour),
  .minute       (result.minute),
  .second       (result.second),
  .millisecond  (result.millisecond)
);

>>> bench/epoch_ms_to_calendar_time_tb.sv
// Self-checking testbench for the epoch-milliseconds to calendar time converter.
`timescale 1ns / 1ps

module epoch_ms_to_calendar_time_tb;
  import ecal_pkg::*;

  localparam int STAMP_BITS = 44;

  // The pipeline is ten stages deep; the final tail is scaled from this depth.
  localparam int PIPE_DEPTH = 10;

  // Cycles without any word moving on any channel before the run is abandoned.
  // The longest gap or stall is far shorter, so this leaves a wide margin.
  localparam int IDLE_LIMIT = 1000;

  localparam longint unsigned DAY_MS = 64'd86400000;

  // Last whole day that a STAMP_BITS-wide timestamp can reach.
  localparam int unsigned LAST_DAY = 203613;

  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

  // One complete result word, date and time of day side by side.
  typedef struct packed {
    ecal_date_t date;
    ecal_tod_t  tod;
  } calendar_word_t;

  // Holds the zone offset the block is running with and the calendar words
  // it owes us, oldest first.
  class calendar_book;
    logic [ZONE_W-1:0] zone_hours;
    calendar_word_t    owed_words[$];
    int unsigned       mismatches;

    function new();
      zone_hours = '0;
      mismatches = 0;
    endfunction

    function void set_zone(logic [ZONE_W-1:0] hours);
      zone_hours = hours;
    endfunction

    function int unsigned pending();
      return owed_words.size();
    endfunction

    // Splits the zoned timestamp into whole days and time of day, then walks
    // the day count through 400-year eras to get the Gregorian date. Days are
    // counted from 1 March of year 0 so that the leap day falls last in the
    // year, which keeps the month arithmetic linear.
    function calendar_word_t stamp_to_calendar(logic [STAMP_BITS-1:0] stamp);
      longint unsigned total, days, rest;
      longint unsigned shifted, era, doe, yoe, doy, mp, dd, mm, yy;
      calendar_word_t  w;
      total = 64'(stamp) + 64'(zone_hours) * MS_PER_HOUR;
      days  = total / DAY_MS;
      rest  = total % DAY_MS;
      w.tod.hour        = HOUR_W'(rest / MS_PER_HOUR);
      rest              = rest % MS_PER_HOUR;
      w.tod.minute      = MIN_W'(rest / MS_PER_MIN);
      rest              = rest % MS_PER_MIN;
      w.tod.second      = SEC_W'(rest / MS_PER_SEC);
      w.tod.millisecond = MSEC_W'(rest % MS_PER_SEC);

      shifted = days + 64'd719468;
      era     = shifted / 64'd146097;
      doe     = shifted - era * 64'd146097;
      yoe     = (doe - doe / 64'd1460 + doe / 64'd36524 - doe / 64'd146096) / 64'd365;
      doy     = doe - (64'd365 * yoe + yoe / 64'd4 - yoe / 64'd100);
      mp      = (64'd5 * doy + 64'd2) / 64'd153;
      dd      = doy - (64'd153 * mp + 64'd2) / 64'd5 + 64'd1;
      mm      = (mp < 64'd10) ? mp + 64'd3 : mp - 64'd9;
      yy      = yoe + era * 64'd400 + ((mm <= 64'd2) ? 64'd1 : 64'd0);
      w.date.year         = YEAR_W'(yy);
      w.date.month        = MONTH_W'(mm);
      w.date.day_of_month = DOM_W'(dd);
      return w;
    endfunction

    function string show(calendar_word_t w);
      return $sformatf("%0d-%0d-%0d %0d:%0d:%0d.%0d", w.date.year, w.date.month,
                       w.date.day_of_month, w.tod.hour, w.tod.minute, w.tod.second,
                       w.tod.millisecond);
    endfunction

    function void note_stamp(logic [STAMP_BITS-1:0] stamp);
      owed_words.push_back(stamp_to_calendar(stamp));
    endfunction

    function void check_result(calendar_word_t got);
      calendar_word_t want;
      string          bad;
      if (owed_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word %s arrived with nothing outstanding", $realtime,
                   show(got));
        return;
      end
      want = owed_words.pop_front();
      bad  = "";
      if (got.date.year !== want.date.year) bad = {bad, " year"};
      if (got.date.month !== want.date.month) bad = {bad, " month"};
      if (got.date.day_of_month !== want.date.day_of_month) bad = {bad, " day_of_month"};
      if (got.tod.hour !== want.tod.hour) bad = {bad, " hour"};
      if (got.tod.minute !== want.tod.minute) bad = {bad, " minute"};
      if (got.tod.second !== want.tod.second) bad = {bad, " second"};
      if (got.tod.millisecond !== want.tod.millisecond) bad = {bad, " millisecond"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: wrong%s: expected %s, got %s", $realtime, bad, show(want),
                   show(got));
      end
    endfunction

    // Anything still owed once the block has gone quiet was lost.
    function void check_leftovers();
      calendar_word_t want;
      while (owed_words.size() != 0) begin
        want = owed_words.pop_front();
        mismatches++;
        if (mismatches <= 10)
          $display("expected word %s never arrived", show(want));
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  ecal_in_if #(.STAMP_BITS(STAMP_BITS)) stamp_ch ();
  ecal_cfg_if cfg_ch ();
  ecal_out_if result_ch ();

  epoch_ms_to_calendar_time #(
    .STAMP_BITS(STAMP_BITS)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .stamp (stamp_ch),
    .cfg   (cfg_ch),
    .result(result_ch)
  );

  calendar_book   book;
  calendar_word_t seen_word;
  int unsigned    quiet_cycles;

  // When set, neither the sender nor the receiver inserts any gaps.
  bit no_idling;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Most gaps are absent or short; now and then a long one lands.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_idling || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Random timestamps: plain random words for bit coverage, the last hours of
  // a day so that the zone offset pushes the date over midnight, the first
  // second after midnight, small stamps near the epoch and the top of range.
  function automatic logic [STAMP_BITS-1:0] random_stamp();
    int unsigned     roll;
    longint unsigned day;
    logic [63:0]     wide;
    roll = $urandom_range(0, 99);
    wide = {$urandom, $urandom};
    day  = 64'($urandom_range(0, LAST_DAY));
    if (roll < 45) return wide[STAMP_BITS-1:0];
    if (roll < 65)
      return STAMP_BITS'(day * DAY_MS + DAY_MS - 64'($urandom_range(1, 32 * 3600000)));
    if (roll < 78) return STAMP_BITS'(day * DAY_MS + 64'($urandom_range(0, 999)));
    if (roll < 88) return STAMP_BITS'(wide[31:0]);
    return STAMP_MAX - STAMP_BITS'(wide[30:0]);
  endfunction

  // Offers one timestamp, after an optional gap, and returns at the edge on
  // which it is taken. valid is left high so that a following word can go
  // out on the very next cycle.
  task automatic send_stamp(input logic [STAMP_BITS-1:0] stamp);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      stamp_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stamp_ch.valid        <= 1'b1;
    stamp_ch.epoch_millis <= stamp;
    do @(posedge clk); while (stamp_ch.ready !== 1'b1);
  endtask

  // Stops sending and waits for every outstanding result, so the block is
  // idle afterwards and the zone offset may be changed.
  task automatic settle();
    stamp_ch.valid <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
  endtask

  task automatic write_zone(input logic [ZONE_W-1:0] hours);
    cfg_ch.valid             <= 1'b1;
    cfg_ch.zone_offset_hours <= hours;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
  endtask

  // Receiver: ready drops for random stretches, which with the skid register
  // exercises the stall path at every depth of the pipeline.
  initial begin
    int unsigned gap;
    result_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      repeat (1 + $urandom_range(0, 6)) @(posedge clk);
    end
  end

  // Watches all three channels. Values are read at the edge before any of
  // this edge's updates land, so every word is seen exactly as it was taken.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (cfg_ch.valid && cfg_ch.ready) begin
        book.set_zone(cfg_ch.zone_offset_hours);
        quiet_cycles = 0;
      end
      if (stamp_ch.valid && stamp_ch.ready) begin
        book.note_stamp(stamp_ch.epoch_millis);
        quiet_cycles = 0;
      end
      if (result_ch.valid && result_ch.ready) begin
        seen_word.date.year         = result_ch.year;
        seen_word.date.month        = result_ch.month;
        seen_word.date.day_of_month = result_ch.day_of_month;
        seen_word.tod.hour          = result_ch.hour;
        seen_word.tod.minute        = result_ch.minute;
        seen_word.tod.second        = result_ch.second;
        seen_word.tod.millisecond   = result_ch.millisecond;
        book.check_result(seen_word);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    logic [STAMP_BITS-1:0] corner_stamps[$];
    logic [ZONE_W-1:0]     zone;
    book      = new();
    no_idling = 1'b0;

    rst                      = 1'b1;
    stamp_ch.valid           = 1'b0;
    stamp_ch.epoch_millis    = '0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.zone_offset_hours = '0;

    // The epoch itself, the top of the stamp range and alternating bit
    // patterns, then the last and first millisecond around midnight.
    corner_stamps.push_back('0);
    corner_stamps.push_back(STAMP_MAX);
    corner_stamps.push_back(44'h555_5555_5555);
    corner_stamps.push_back(44'hAAA_AAAA_AAAA);
    corner_stamps.push_back(STAMP_BITS'(DAY_MS - 1));
    corner_stamps.push_back(STAMP_BITS'(DAY_MS));
    // A mid-day time with every field away from its limits.
    corner_stamps.push_back(STAMP_BITS'(64'd12345 * DAY_MS + 64'd45296789));
    // The turn of the first year, and the first leap day at 29 February 1972.
    corner_stamps.push_back(STAMP_BITS'(64'd365 * DAY_MS - 1));
    corner_stamps.push_back(STAMP_BITS'(64'd365 * DAY_MS));
    corner_stamps.push_back(STAMP_BITS'(64'd789 * DAY_MS));
    corner_stamps.push_back(STAMP_BITS'(64'd790 * DAY_MS - 1));
    // 2000 is a leap year since it divides by 400.
    corner_stamps.push_back(STAMP_BITS'(64'd11016 * DAY_MS));
    corner_stamps.push_back(STAMP_BITS'(64'd11017 * DAY_MS));
    // 2100 is not: 28 February runs straight into 1 March.
    corner_stamps.push_back(STAMP_BITS'(64'd47541 * DAY_MS - 1));
    corner_stamps.push_back(STAMP_BITS'(64'd47541 * DAY_MS));
    // 2400 is a leap year again, at the start of a new 400-year era.
    corner_stamps.push_back(STAMP_BITS'(64'd157113 * DAY_MS));
    corner_stamps.push_back(STAMP_BITS'(64'd157114 * DAY_MS - 1));
    corner_stamps.push_back(STAMP_BITS'(64'd157114 * DAY_MS));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The corner stamps run with the zone offset still at its reset value.
    foreach (corner_stamps[i]) send_stamp(corner_stamps[i]);
    settle();

    // Each phase sets a new zone offset on an idle block. The top of the
    // register (above the nominal 23), then 23 and zero come first; one phase runs
    // flat out with no gaps on either side, and one pauses halfway until
    // every result is back.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       zone = '1;
        1:       zone = 5'd23;
        2:       zone = '0;
        3:       zone = 5'd1;
        default: zone = ZONE_W'($urandom_range(0, 31));
      endcase
      write_zone(zone);
      no_idling = (phase == 2);
      for (int n = 0; n < 150; n++) begin
        if (phase == 4 && n == 75) settle();
        send_stamp(random_stamp());
      end
      settle();
    end
    no_idling = 1'b0;

    // Give any stray word time to surface before the final verdict.
    repeat (3 * PIPE_DEPTH) @(posedge clk);
    book.check_leftovers();
    if (book.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
